### sv/rws_pkg.sv
package rws_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int FITNESS_BITS = 16;

    localparam int ACTION_BITS   = 2;
    localparam int FRACTION_BITS = 16;
    localparam int STATUS_BITS   = 2;
    localparam int INDEX_BITS    = 6;

    localparam int COUNT_BITS = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_BITS  = $clog2(MAX_ENTRIES);
    localparam int TOTAL_BITS = FITNESS_BITS + ADDR_BITS;
    localparam int PROD_BITS  = FRACTION_BITS + TOTAL_BITS;

    typedef logic [ACTION_BITS-1:0]   action_t;
    typedef logic [FITNESS_BITS-1:0]  fitness_t;
    typedef logic [FRACTION_BITS-1:0] fraction_t;
    typedef logic [STATUS_BITS-1:0]   status_t;
    typedef logic [INDEX_BITS-1:0]    index_t;
    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [ADDR_BITS-1:0]     addr_t;
    typedef logic [TOTAL_BITS-1:0]    total_t;
    typedef logic [PROD_BITS-1:0]     prod_t;

    // action codes
    localparam action_t ACT_CLEAR  = 2'd0;
    localparam action_t ACT_APPEND = 2'd1;
    localparam action_t ACT_SELECT = 2'd2;
    localparam action_t ACT_NOP    = 2'd3;

    // status codes
    localparam status_t ST_DONE   = 2'd0;
    localparam status_t ST_PICKED = 2'd1;
    localparam status_t ST_NONE   = 2'd2;
    localparam status_t ST_FULL   = 2'd3;

endpackage

### sv/rws_if.sv
interface rws_in_if;
    logic                 valid;
    logic                 ready;
    rws_pkg::action_t     action;
    logic [15:0]          fitness_value;
    rws_pkg::fraction_t   random_fraction;

    modport source (output valid, output action, output fitness_value,
                    output random_fraction, input ready);
    modport sink   (input valid, input action, input fitness_value,
                    input random_fraction, output ready);
endinterface

interface rws_out_if;
    logic               valid;
    logic               ready;
    rws_pkg::status_t   status;
    rws_pkg::index_t    chosen_index;

    modport source (output valid, output status, output chosen_index, input ready);
    modport sink   (input valid, input status, input chosen_index, output ready);
endinterface

### sv/roulette_wheel_selector.sv
// channel     | dir | payload                                 | handshake
// item_in     | in  | action, fitness_value, random_fraction  | valid / ready
// result_out  | out | status, chosen_index                    | valid / ready
//
// clear, append and no-op pass from accept through S_RESULT to the result register
// a select with entries and a nonzero total walks n entries (up to 64):
// the multiply in S_MUL, then one table entry per cycle in S_WALK through the
// single registered read port and the shared compare/subtract unit, then S_RESULT
// rst_n clears the entry count, the total and all control; table contents stay
// a result waiting on result_out does not block accepting the next item,
// but the sequencer holds the following result until the output slot frees
module roulette_wheel_selector (
    input  logic             clk,
    input  logic             rst_n,
    rws_in_if.sink           item_in,
    rws_out_if.source        result_out
);
    import rws_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MUL    = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    // control state
    logic [1:0] state_reg, state_next;
    count_t     count_reg, count_next;
    total_t     total_reg, total_next;
    logic       out_valid_reg, out_valid_next;

    // datapath registers
    fraction_t  frac_reg, frac_next;
    total_t     thr_reg, thr_next;
    addr_t      idx_reg, idx_next;
    status_t    res_status_reg, res_status_next;
    index_t     res_index_reg, res_index_next;
    status_t    out_status_reg, out_status_next;
    index_t     out_index_reg, out_index_next;

    // fitness table, one write and one registered read port
    fitness_t   table_mem [MAX_ENTRIES];
    fitness_t   rd_data_reg;
    logic       wr_en;
    addr_t      wr_addr;
    fitness_t   wr_data;

    logic       accept;
    logic       slot_free;
    prod_t      product;
    total_t     entry_ext;
    count_t     idx_plus;

    assign item_in.ready           = (state_reg == S_IDLE);
    assign accept                  = item_in.valid && item_in.ready;
    assign slot_free               = !out_valid_reg || result_out.ready;

    assign result_out.valid        = out_valid_reg;
    assign result_out.status       = out_status_reg;
    assign result_out.chosen_index = out_index_reg;

    // threshold = fraction * total / 2^16, always below total when total nonzero
    assign product   = PROD_BITS'(frac_reg) * PROD_BITS'(total_reg);
    assign entry_ext = TOTAL_BITS'(rd_data_reg);
    assign idx_plus  = COUNT_BITS'(idx_reg) + COUNT_BITS'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        frac_next       = frac_reg;
        thr_next        = thr_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[ADDR_BITS-1:0];
        wr_data         = item_in.fitness_value[FITNESS_BITS-1:0];

        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_DONE;
                    res_index_next  = '0;
                    idx_next        = '0;
                    frac_next       = item_in.random_fraction;
                    state_next      = S_RESULT;
                    unique case (item_in.action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        ACT_APPEND:
                        begin
                            if (count_reg == COUNT_BITS'(MAX_ENTRIES))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + COUNT_BITS'(1);
                                total_next = total_reg + TOTAL_BITS'(wr_data);
                            end
                        end
                        ACT_SELECT:
                        begin
                            if (count_reg == '0 || total_reg == '0)
                            begin
                                res_status_next = ST_NONE;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                        ACT_NOP:
                        begin
                            res_status_next = ST_DONE;
                        end
                        default:
                        begin
                            res_status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                // entry 0 is read at this edge
                thr_next   = product[PROD_BITS-1:FRACTION_BITS];
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (thr_reg < entry_ext)
                begin
                    res_status_next = ST_PICKED;
                    res_index_next  = INDEX_BITS'(idx_reg);
                    state_next      = S_RESULT;
                end
                else if (idx_plus == count_reg)
                begin
                    // walk ran off the end, not reachable with a nonzero total
                    res_status_next = ST_NONE;
                    res_index_next  = '0;
                    state_next      = S_RESULT;
                end
                else
                begin
                    thr_next = thr_reg - entry_ext;
                    idx_next = idx_reg + ADDR_BITS'(1);
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg       <= frac_next;
        thr_reg        <= thr_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
    end

    // table write port and read port, read address follows the walk index
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[idx_next];
    end

endmodule
